### sv/qsm_pkg.sv
`default_nettype none
package qsm_pkg;

	typedef enum logic [2:0] {
		MODE_16  = 3'd0,
		MODE_32  = 3'd1,
		MODE_64  = 3'd2,
		MODE_128 = 3'd3,
		MODE_256 = 3'd4
	} mode_t;

	// one symbol request from the slicer to the mapper
	typedef struct packed {
		logic [7:0] sym;
		mode_t      mode;
		logic       last;
	} sym_req_t;

	// first-quadrant points, x in the high nibble, y in the low
	localparam logic [7:0] PTS32 [0:7] = '{
		8'h11, 8'h31, 8'h35, 8'h51, 8'h13, 8'h33, 8'h15, 8'h53
	};

	localparam logic [7:0] PTS128 [0:31] = '{
		8'h11, 8'h31, 8'h13, 8'h33, 8'h71, 8'h51, 8'h73, 8'h53,
		8'h79, 8'h59, 8'h7B, 8'h5B, 8'h91, 8'hB1, 8'h93, 8'hB3,
		8'h17, 8'h37, 8'h15, 8'h35, 8'h77, 8'h57, 8'h75, 8'h55,
		8'h19, 8'h39, 8'h1B, 8'h3B, 8'h97, 8'hB7, 8'h95, 8'hB5
	};

	// also serves 16 and 64 QAM through its leading entries
	localparam logic [7:0] PTS256 [0:63] = '{
		8'h11, 8'h31, 8'h13, 8'h33, 8'h71, 8'h51, 8'h73, 8'h53,
		8'h17, 8'h37, 8'h15, 8'h35, 8'h77, 8'h57, 8'h75, 8'h55,
		8'hF1, 8'hD1, 8'hF3, 8'hD3, 8'h91, 8'hB1, 8'h93, 8'hB3,
		8'hF7, 8'hD7, 8'hF5, 8'hD5, 8'h97, 8'hB7, 8'h95, 8'hB5,
		8'h1F, 8'h3F, 8'h1D, 8'h3D, 8'h7F, 8'h5F, 8'h7D, 8'h5D,
		8'h19, 8'h39, 8'h1B, 8'h3B, 8'h79, 8'h59, 8'h7B, 8'h5B,
		8'hFF, 8'hDF, 8'hFD, 8'hDD, 8'h9F, 8'hBF, 8'h9D, 8'hBD,
		8'hF9, 8'hD9, 8'hFB, 8'hDB, 8'h99, 8'hB9, 8'h9B, 8'hBB
	};

	function automatic logic [7:0] point_lookup(mode_t mode, logic [5:0] idx);
		logic [7:0] p;
		unique case (mode)
			MODE_32:  p = PTS32[idx[2:0]];
			MODE_128: p = PTS128[idx[4:0]];
			default:  p = PTS256[idx];
		endcase
		return p;
	endfunction

endpackage
`default_nettype wire

### sv/qam_symbol_mapper.sv
`default_nettype none
// Input takes one byte per cycle while each yields one symbol and the queue is
// not full; a byte that yields two stalls the next until its second is pushed.
// The output emits one symbol a cycle unless out_stall holds it.
// Reset (arst_n, async, active low) clears carried bits, quadrant history,
// queue and output valid; qam_mode returns to 64 QAM.
module qam_symbol_mapper #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic signed [4:0] i_level,
	output logic signed [4:0] q_level,
	output logic             last_of_byte
);
	import qsm_pkg::*;

	mode_t    qam_mode_q;
	logic     push;
	sym_req_t push_req;
	logic     q_full;
	logic     pop;
	logic     head_valid;
	sym_req_t head_req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			qam_mode_q <= MODE_64;
		else if (cfg_we && (cfg_wdata <= 3'(MODE_256)))
			qam_mode_q <= mode_t'(cfg_wdata);
	end

	qsm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (qam_mode_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.q_full    (q_full),
		.push      (push),
		.push_req  (push_req)
	);

	qsm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_req   (push_req),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_req   (head_req)
	);

	qsm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_req     (head_req),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.i_level      (i_level),
		.q_level      (q_level),
		.last_of_byte (last_of_byte)
	);

endmodule
`default_nettype wire

### sv/qsm_front.sv
`default_nettype none
module qsm_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire qsm_pkg::mode_t   mode,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [7:0]       data_byte,
	input  wire logic             q_full,
	output logic                  push,
	output qsm_pkg::sym_req_t     push_req
);
	import qsm_pkg::*;

	logic [6:0]  pend_q;
	logic [2:0]  pcnt_q;
	logic [1:0]  cnt_s1;
	logic [7:0]  sym_a_s1;
	logic [7:0]  sym_b_s1;
	mode_t       mode_s1;

	logic [14:0] acc;
	logic [3:0]  count;
	logic [3:0]  w;
	logic [3:0]  c1;
	logic [3:0]  c2;
	logic [3:0]  rem;
	logic [7:0]  mask;
	logic [7:0]  sym0;
	logic [7:0]  sym1;
	logic        has_one;
	logic        has_two;
	logic [1:0]  n;
	logic        accept;

	always_comb begin
		acc     = {pend_q, data_byte};
		count   = {1'b0, pcnt_q} + 4'd8;
		w       = {1'b0, mode} + 4'd4;
		has_one = count >= w;
		has_two = {1'b0, count} >= {w, 1'b0};
		c1      = count - w;
		c2      = c1 - w;
		mask    = ~(8'hFF << w);
		sym0    = 8'(acc >> c1) & mask;
		sym1    = 8'(acc >> c2) & mask;
		priority if (has_two) begin
			n   = 2'd2;
			rem = c2;
		end else if (has_one) begin
			n   = 2'd1;
			rem = c1;
		end else begin
			n   = 2'd0;
			rem = count;
		end
	end

	always_comb begin
		push          = (cnt_s1 != 2'd0) && !q_full;
		push_req.sym  = sym_a_s1;
		push_req.mode = mode_s1;
		push_req.last = (cnt_s1 == 2'd1);
		in_stall      = !((cnt_s1 == 2'd0) || ((cnt_s1 == 2'd1) && push));
		accept        = in_valid && !in_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			pcnt_q <= '0;
			cnt_s1 <= '0;
		end else if (accept) begin
			pend_q <= 7'(acc & ~(15'h7FFF << rem));
			pcnt_q <= rem[2:0];
			cnt_s1 <= n;
		end else if (push) begin
			cnt_s1 <= cnt_s1 - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sym_a_s1 <= sym0;
			sym_b_s1 <= sym1;
			mode_s1  <= mode;
		end else if (push) begin
			sym_a_s1 <= sym_b_s1;
		end
	end

endmodule
`default_nettype wire

### sv/qsm_queue.sv
`default_nettype none
module qsm_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire qsm_pkg::sym_req_t push_req,
	output logic                   full,
	input  wire logic              pop,
	output logic                   head_valid,
	output qsm_pkg::sym_req_t      head_req
);
	import qsm_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	sym_req_t        mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_req   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_req;
	end

`ifndef ASSERT_OFF
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("request pushed into a full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> !pop) else $error("request popped from an empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH)) else $error("queue count overflow");
`endif

endmodule
`default_nettype wire

### sv/qsm_back.sv
`default_nettype none
module qsm_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              head_valid,
	input  wire qsm_pkg::sym_req_t head_req,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic signed [4:0]      i_level,
	output logic signed [4:0]      q_level,
	output logic                   last_of_byte
);
	import qsm_pkg::*;

	logic              prev_i_q;
	logic              prev_q_q;
	logic              out_valid_q;
	logic signed [4:0] i_level_q;
	logic signed [4:0] q_level_q;
	logic              last_q;

	logic [2:0]        a_pos;
	logic [2:0]        b_pos;
	logic              a;
	logic              b;
	logic              d;
	logic              qi;
	logic              qq;
	logic [5:0]        idx;
	logic [7:0]        pt;
	logic [4:0]        x;
	logic [4:0]        y;
	logic [4:0]        iv;
	logic [4:0]        qv;

	always_comb begin
		a_pos = head_req.mode + 3'd3;
		b_pos = head_req.mode + 3'd2;
		a     = head_req.sym[a_pos];
		b     = head_req.sym[b_pos];
		d     = a ^ b;
		qi    = (!d & (a ^ prev_i_q)) | (d & (a ^ prev_q_q));
		qq    = (!d & (b ^ prev_q_q)) | (d & (b ^ prev_i_q));
		idx   = 6'(head_req.sym & ~(8'hFF << b_pos));
		pt    = point_lookup(head_req.mode, idx);
		x     = {1'b0, pt[7:4]};
		y     = {1'b0, pt[3:0]};
		unique case ({qi, qq})
			2'b00: begin iv = x;  qv = y;  end
			2'b01: begin iv = y;  qv = -x; end
			2'b10: begin iv = -y; qv = x;  end
			default: begin iv = -x; qv = -y; end
		endcase
		pop = head_valid && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_i_q    <= 1'b0;
			prev_q_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				prev_i_q <= qi;
				prev_q_q <= qq;
			end
			if (pop)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			i_level_q <= signed'(iv);
			q_level_q <= signed'(qv);
			last_q    <= head_req.last;
		end
	end

	assign out_valid    = out_valid_q;
	assign i_level      = i_level_q;
	assign q_level      = q_level_q;
	assign last_of_byte = last_q;

`ifndef ASSERT_OFF
	a_odd_levels: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (i_level_q[0] && q_level_q[0])) else $error("even level driven");
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (i_level_q != 5'sh10 && q_level_q != 5'sh10))
		else $error("level out of range");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !pop) else $error("stalled result overwritten");
`endif

endmodule
`default_nettype wire
